// ===== hw/rtl/itq_pkg.sv =====
package itq_pkg;

  // Table size and kept buffer id bits.
  localparam int TABLE_DEPTH    = 8;
  localparam int BUFFER_ID_BITS = 8;

  localparam int SLOT_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int BUF_KEEP = (BUFFER_ID_BITS < 8) ? BUFFER_ID_BITS : 8;

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_REQUEST = 3'd1,
    OP_QUERY   = 3'd2,
    OP_TICK    = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    EV_ADDED    = 3'd0,
    EV_FULL     = 3'd1,
    EV_TRANSMIT = 3'd2,
    EV_NO_MATCH = 3'd3,
    EV_ANSWER   = 3'd4,
    EV_EXPIRED  = 3'd5,
    EV_FREED    = 3'd6,
    EV_DONE     = 3'd7
  } event_t;

  localparam logic [1:0] MODE_SHORT = 2'd1;
  localparam logic [1:0] MODE_LONG  = 2'd2;

  // One table entry as held in the slot memory.
  typedef struct packed {
    logic [15:0]         expiry;
    logic                ack;
    logic [7:0]          dsn;
    logic [7:0]          handle;
    logic [BUF_KEEP-1:0] buffer;
    logic [1:0]          mode;
    logic [63:0]         address;
  } slot_t;

  // Access from the sequencer to the slot memory.
  typedef struct packed {
    logic      we;
    slot_idx_t waddr;
    slot_t     wdata;
    logic      re;
    slot_idx_t raddr;
  } ram_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_SCAN_LAST,
    S_SCAN_END,
    S_XMIT,
    S_TICK_SEL,
    S_TICK_CHK,
    S_CLR_SEL,
    S_CLR_EMIT,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/itq_if.sv =====
// Command channel: one request per operation.
interface itq_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [63:0] address;
  logic [1:0]  address_mode;
  logic [7:0]  buffer_id;
  logic        ack_request;
  logic [7:0]  sequence_number;
  logic [7:0]  frame_handle;

  modport source (output valid, operation, address, address_mode, buffer_id, ack_request,
                  sequence_number, frame_handle, input ready);
  modport sink (input valid, operation, address, address_mode, buffer_id, ack_request,
                sequence_number, frame_handle, output ready);
endinterface

// Event channel: one or more results per request.
interface itq_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic        found;
  logic [7:0]  out_buffer_id;
  logic [63:0] out_address;
  logic [1:0]  out_address_mode;
  logic        out_ack_request;
  logic [7:0]  out_sequence_number;
  logic [7:0]  out_handle;
  logic        set_frame_pending;
  logic        last;

  modport source (output valid, event_res, found, out_buffer_id, out_address,
                  out_address_mode, out_ack_request, out_sequence_number, out_handle,
                  set_frame_pending, last, input ready);
  modport sink (input valid, event_res, found, out_buffer_id, out_address,
                out_address_mode, out_ack_request, out_sequence_number, out_handle,
                set_frame_pending, last, output ready);
endinterface

// ===== hw/rtl/indirect_transaction_queue_top.sv =====
// Channel   Direction  Handshake      Carries
// cmd       in         valid/ready    operation and frame descriptor
// evt       out        valid/ready    one or more events per request, last marks the end
// apb       in         psel/penable   persist_time at address 0
//
// Requests are taken one at a time. A pending query or a data request walks
// the slot memory one entry a cycle through its single read port. Tick and
// clear pick entries by age rank and read one entry per visit. A full output
// register stalls tick and clear at each event and any request at its last event.
// Reset is synchronous and empties the table at once; no clearing pass.
module indirect_transaction_queue_top import itq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  itq_cmd_if.sink     cmd,
  itq_evt_if.source   evt,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] persist_time;
  ram_req_t    ram_req;
  slot_t       ram_rdata;

  itq_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .persist_time (persist_time)
  );

  itq_ram #(
    .DATA_W ($bits(slot_t)),
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (SLOT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  itq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .evt          (evt),
    .persist_time (persist_time),
    .ram_req      (ram_req),
    .ram_rdata    (ram_rdata)
  );

endmodule

// ===== hw/rtl/itq_ram.sv =====
module itq_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Single write port and a registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/itq_cfg.sv =====
module itq_cfg import itq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] persist_time
);

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr == 3'd0);

  // The persistence register sits at address zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      persist_time <= '0;
    end else if (wr_hit) begin
      persist_time <= pwdata[15:0];
    end
  end

  assign prdata = (paddr == 3'd0) ? {16'd0, persist_time} : 32'd0;

endmodule

// ===== hw/rtl/itq_ctrl.sv =====
module itq_ctrl import itq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  itq_cmd_if.sink     cmd,
  itq_evt_if.source   evt,
  input  logic [15:0] persist_time,
  output ram_req_t    ram_req,
  input  slot_t       ram_rdata
);

  state_t state, state_next;

  // Latched request.
  op_t         op;
  logic [63:0] addr;
  logic [1:0]  mode;
  logic [7:0]  buf_id;
  logic        ack;
  logic [7:0]  dsn;
  logic [7:0]  handle;

  // Slot bookkeeping held in flops.
  logic [TABLE_DEPTH-1:0] valid;
  slot_idx_t              rank [TABLE_DEPTH];

  // Walk registers.
  slot_idx_t idx, idx_next;
  slot_idx_t prev, prev_next;
  logic      pend, pend_next;
  logic      best_found, best_found_next;
  slot_idx_t best_slot, best_slot_next;
  cnt_t      r, r_next;
  slot_idx_t cur, cur_next;

  // Table updates and result load.
  logic      add_en, remove_en;
  slot_idx_t remove_slot;
  logic      emit, can_emit, carry, found_n, fp_n, last_n;
  event_t    ev_n;

  cnt_t      count, target;
  logic      full;
  slot_idx_t free_slot, hit_slot;
  logic      hit, match, better;

  assign cmd.ready = (state == S_IDLE);
  assign can_emit  = !evt.valid || evt.ready;

  // Occupancy and the first free slot.
  always_comb begin
    count     = '0;
    free_slot = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      count = count + cnt_t'(valid[i]);
      if (!valid[i]) begin
        free_slot = slot_idx_t'(i);
      end
    end
    full = &valid;
  end

  // Slot holding a given age rank.
  assign target = (state == S_CLR_SEL) ? count - cnt_t'(1) : r;
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (valid[i] && (cnt_t'(rank[i]) == target)) begin
        hit      = 1'b1;
        hit_slot = slot_idx_t'(i);
      end
    end
  end

  // Address compare of the entry read in the previous cycle.
  always_comb begin
    if (mode == MODE_LONG) begin
      match = valid[prev] && (ram_rdata.address == addr);
    end else if (mode == MODE_SHORT) begin
      match = valid[prev] && (ram_rdata.address[15:0] == addr[15:0]);
    end else begin
      match = 1'b0;
    end
    better = !best_found || (rank[prev] < rank[best_slot]);
  end

  // Sequencer.
  always_comb begin
    state_next      = state;
    idx_next        = idx;
    prev_next       = prev;
    pend_next       = pend;
    best_found_next = best_found;
    best_slot_next  = best_slot;
    r_next          = r;
    cur_next        = cur;
    ram_req         = '0;
    ram_req.raddr   = idx;
    ram_req.wdata   = ram_rdata;
    add_en          = 1'b0;
    remove_en       = 1'b0;
    remove_slot     = cur;
    emit            = 1'b0;
    ev_n            = EV_DONE;
    found_n         = 1'b0;
    carry           = 1'b0;
    fp_n            = 1'b0;
    last_n          = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          pend_next       = 1'b0;
          best_found_next = 1'b0;
          idx_next        = '0;
          r_next          = '0;
          unique case (op_t'(cmd.operation))
            OP_ADD:              state_next = S_ADD;
            OP_REQUEST, OP_QUERY: state_next = S_SCAN;
            OP_TICK:             state_next = S_TICK_SEL;
            OP_CLEAR:            state_next = S_CLR_SEL;
            default:             state_next = S_DONE;
          endcase
        end
      end
      S_ADD: begin
        if (can_emit) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (full) begin
            ev_n = EV_FULL;
          end else begin
            ev_n                  = EV_ADDED;
            fp_n                  = 1'b1;
            add_en                = 1'b1;
            ram_req.we            = 1'b1;
            ram_req.waddr         = free_slot;
            ram_req.wdata.expiry  = persist_time;
            ram_req.wdata.ack     = ack;
            ram_req.wdata.dsn     = dsn;
            ram_req.wdata.handle  = handle;
            ram_req.wdata.buffer  = buf_id[BUF_KEEP-1:0];
            ram_req.wdata.mode    = mode;
            ram_req.wdata.address = addr;
          end
        end
      end
      S_SCAN, S_SCAN_LAST: begin
        if (pend && match && better) begin
          best_found_next = 1'b1;
          best_slot_next  = prev;
        end
        if (state == S_SCAN) begin
          ram_req.re = 1'b1;
          prev_next  = idx;
          pend_next  = 1'b1;
          if (idx == slot_idx_t'(TABLE_DEPTH - 1)) begin
            state_next = S_SCAN_LAST;
          end else begin
            idx_next = idx + slot_idx_t'(1);
          end
        end else begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        if (op == OP_QUERY) begin
          if (can_emit) begin
            emit       = 1'b1;
            ev_n       = EV_ANSWER;
            found_n    = best_found;
            state_next = S_IDLE;
          end
        end else if (!best_found) begin
          if (can_emit) begin
            emit       = 1'b1;
            ev_n       = EV_NO_MATCH;
            state_next = S_IDLE;
          end
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = best_slot;
          state_next    = S_XMIT;
        end
      end
      S_XMIT: begin
        if (can_emit) begin
          emit        = 1'b1;
          ev_n        = EV_TRANSMIT;
          found_n     = 1'b1;
          carry       = 1'b1;
          remove_en   = 1'b1;
          remove_slot = best_slot;
          state_next  = S_IDLE;
        end
      end
      S_TICK_SEL: begin
        if (!hit) begin
          state_next = S_DONE;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = hit_slot;
          cur_next      = hit_slot;
          state_next    = S_TICK_CHK;
        end
      end
      S_TICK_CHK: begin
        if (ram_rdata.expiry == 16'd0) begin
          if (can_emit) begin
            emit       = 1'b1;
            ev_n       = EV_EXPIRED;
            carry      = 1'b1;
            last_n     = 1'b0;
            remove_en  = 1'b1;
            state_next = S_TICK_SEL;
          end
        end else begin
          ram_req.we           = 1'b1;
          ram_req.waddr        = cur;
          ram_req.wdata.expiry = ram_rdata.expiry - 16'd1;
          r_next               = r + cnt_t'(1);
          state_next           = S_TICK_SEL;
        end
      end
      S_CLR_SEL: begin
        if ((count == '0) || !hit) begin
          state_next = S_DONE;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = hit_slot;
          cur_next      = hit_slot;
          state_next    = S_CLR_EMIT;
        end
      end
      S_CLR_EMIT: begin
        if (can_emit) begin
          emit       = 1'b1;
          ev_n       = EV_FREED;
          carry      = 1'b1;
          last_n     = 1'b0;
          remove_en  = 1'b1;
          state_next = S_CLR_SEL;
        end
      end
      S_DONE: begin
        if (can_emit) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
    end else begin
      state <= state_next;
      if (add_en) begin
        valid[free_slot] <= 1'b1;
      end
      if (remove_en) begin
        valid[remove_slot] <= 1'b0;
      end
    end
  end

  // Age ranks close the gap left by a removed entry.
  always_ff @(posedge clk) begin
    if (add_en) begin
      rank[free_slot] <= slot_idx_t'(count);
    end
    if (remove_en) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (valid[i] && (rank[i] > rank[remove_slot])) begin
          rank[i] <= rank[i] - slot_idx_t'(1);
        end
      end
    end
  end

  // Walk registers and the latched request.
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    prev       <= prev_next;
    pend       <= pend_next;
    best_found <= best_found_next;
    best_slot  <= best_slot_next;
    r          <= r_next;
    cur        <= cur_next;
    if (cmd.valid && cmd.ready) begin
      op     <= op_t'(cmd.operation);
      addr   <= cmd.address;
      mode   <= cmd.address_mode;
      buf_id <= cmd.buffer_id;
      ack    <= cmd.ack_request;
      dsn    <= cmd.sequence_number;
      handle <= cmd.frame_handle;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      evt.valid <= 1'b0;
    end else if (emit) begin
      evt.valid <= 1'b1;
    end else if (evt.ready) begin
      evt.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      evt.event_res           <= ev_n;
      evt.found               <= found_n;
      evt.set_frame_pending   <= fp_n;
      evt.last                <= last_n;
      evt.out_buffer_id       <= carry ? 8'(ram_rdata.buffer) : 8'd0;
      evt.out_address         <= carry ? ram_rdata.address : 64'd0;
      evt.out_address_mode    <= carry ? ram_rdata.mode : 2'd0;
      evt.out_ack_request     <= carry ? ram_rdata.ack : 1'b0;
      evt.out_sequence_number <= carry ? ram_rdata.dsn : 8'd0;
      evt.out_handle          <= carry ? ram_rdata.handle : 8'd0;
    end
  end

endmodule
